[rtl/mbtc_pkg.sv]
// ----------------------------------------------------------------------------
// mbtc_pkg
// shared types and constants for the modbus/tcp read response correlator
// ----------------------------------------------------------------------------
package mbtc_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int TBL_IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ADDR_KEY_W  = 64;
    localparam int PORT_KEY_W  = 48;
    localparam int START_W     = 16;
    localparam int TBL_WORD_W  = START_W + ADDR_KEY_W + PORT_KEY_W;

    localparam logic [TBL_IDX_W-1:0] TBL_LAST_IDX = TBL_IDX_W'(TABLE_DEPTH - 1);

    localparam logic [15:0] SERVICE_PORT_RESET = 16'd502;

    localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FUNC_READ_INPUT   = 8'h04;

    // frame byte positions, ethernet destination is position 0
    localparam logic [10:0] POS_IP_VER_IHL  = 11'd14;
    localparam logic [10:0] POS_SRC_ADDR_LO = 11'd26;
    localparam logic [10:0] POS_SRC_ADDR_HI = 11'd29;
    localparam logic [10:0] POS_DST_ADDR_LO = 11'd30;
    localparam logic [10:0] POS_DST_ADDR_HI = 11'd33;
    localparam logic [10:0] POS_MAX         = 11'd2047;

    // smallest legal header length in 32-bit words
    localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

    // offsets inside the tcp header and the modbus record
    localparam logic [10:0] TCP_OFS_DATA_OFS = 11'd12;
    localparam logic [10:0] MB_OFS_FUNC      = 11'd7;
    localparam logic [10:0] MB_OFS_BYTE_CNT  = 11'd8;
    localparam logic [10:0] MB_OFS_START_LO  = 11'd9;
    localparam logic [10:0] MB_OFS_INSERT    = 11'd11;

    typedef enum logic [1:0] {
        TBL_IDLE,
        TBL_LOOKUP,
        TBL_INSERT
    } mbtc_tbl_state_t;

    typedef enum logic {
        ST_PARSE,
        ST_LOOKUP
    } mbtc_state_t;

    typedef struct packed {
        logic                  lookup;
        logic                  insert;
        logic [ADDR_KEY_W-1:0] addrs;
        logic [PORT_KEY_W-1:0] ports_txn;
        logic [START_W-1:0]    start;
    } mbtc_tbl_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic               hit;
        logic [START_W-1:0] start;
    } mbtc_tbl_rsp_t;

endpackage

[rtl/mbtc_ram.sv]
// ----------------------------------------------------------------------------
// mbtc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module mbtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/mbtc_table.sv]
// ----------------------------------------------------------------------------
// mbtc_table
// request table: linear lookup and first-free insert with one shared key compare
// ----------------------------------------------------------------------------
module mbtc_table (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mbtc_pkg::mbtc_tbl_req_t req,
    output mbtc_pkg::mbtc_tbl_rsp_t rsp
);

    mbtc_pkg::mbtc_tbl_state_t state_reg, state_next;

    logic [mbtc_pkg::TABLE_DEPTH-1:0]  valid_reg, valid_next;
    logic [mbtc_pkg::TBL_IDX_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                              scan_last_reg, scan_last_next;
    logic [mbtc_pkg::TBL_IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                              cmp_live_reg, cmp_live_next;
    logic [mbtc_pkg::ADDR_KEY_W-1:0]   key_addrs_reg, key_addrs_next;
    logic [mbtc_pkg::PORT_KEY_W-1:0]   key_ports_reg, key_ports_next;
    logic [mbtc_pkg::START_W-1:0]      key_start_reg, key_start_next;

    logic                              ram_wr_en;
    logic [mbtc_pkg::TBL_WORD_W-1:0]   ram_rd_data;

    logic                              match;
    logic                              miss;
    logic                              free_slot;

    mbtc_ram #(
        .WIDTH(mbtc_pkg::TBL_WORD_W),
        .DEPTH(mbtc_pkg::TABLE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (scan_idx_reg),
        .wr_data ({key_start_reg, key_addrs_reg, key_ports_reg}),
        .rd_addr (scan_idx_reg),
        .rd_data (ram_rd_data)
    );

    // shared key compare on the word read in the previous cycle
    assign match = cmp_live_reg && valid_reg[cmp_idx_reg] &&
                   (ram_rd_data[mbtc_pkg::ADDR_KEY_W+mbtc_pkg::PORT_KEY_W-1:0] ==
                    {key_addrs_reg, key_ports_reg});
    assign miss      = cmp_live_reg && !match && (cmp_idx_reg == mbtc_pkg::TBL_LAST_IDX);
    assign free_slot = !valid_reg[scan_idx_reg];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mbtc_pkg::TBL_IDLE: begin
                if (req.lookup) begin
                    state_next = mbtc_pkg::TBL_LOOKUP;
                end else if (req.insert) begin
                    state_next = mbtc_pkg::TBL_INSERT;
                end
            end
            mbtc_pkg::TBL_LOOKUP: begin
                if (match || miss) begin
                    state_next = mbtc_pkg::TBL_IDLE;
                end
            end
            mbtc_pkg::TBL_INSERT: begin
                if (free_slot || scan_idx_reg == mbtc_pkg::TBL_LAST_IDX) begin
                    state_next = mbtc_pkg::TBL_IDLE;
                end
            end
            default: state_next = mbtc_pkg::TBL_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        valid_next     = valid_reg;
        scan_idx_next  = scan_idx_reg;
        scan_last_next = scan_last_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_live_next  = 1'b0;
        key_addrs_next = key_addrs_reg;
        key_ports_next = key_ports_reg;
        key_start_next = key_start_reg;
        ram_wr_en      = 1'b0;
        rsp.busy       = (state_reg != mbtc_pkg::TBL_IDLE);
        rsp.done       = 1'b0;
        rsp.hit        = 1'b0;
        rsp.start      = ram_rd_data[mbtc_pkg::TBL_WORD_W-1 -: mbtc_pkg::START_W];
        unique case (state_reg)
            mbtc_pkg::TBL_IDLE: begin
                if (req.lookup || req.insert) begin
                    key_addrs_next = req.addrs;
                    key_ports_next = req.ports_txn;
                    key_start_next = req.start;
                    scan_idx_next  = '0;
                    scan_last_next = 1'b0;
                end
            end
            mbtc_pkg::TBL_LOOKUP: begin
                if (!scan_last_reg) begin
                    cmp_live_next = 1'b1;
                    cmp_idx_next  = scan_idx_reg;
                    if (scan_idx_reg == mbtc_pkg::TBL_LAST_IDX) begin
                        scan_last_next = 1'b1;
                    end else begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                if (match) begin
                    valid_next[cmp_idx_reg] = 1'b0;
                    rsp.done      = 1'b1;
                    rsp.hit       = 1'b1;
                    cmp_live_next = 1'b0;
                end else if (miss) begin
                    rsp.done      = 1'b1;
                    cmp_live_next = 1'b0;
                end
            end
            mbtc_pkg::TBL_INSERT: begin
                if (free_slot) begin
                    ram_wr_en                = 1'b1;
                    valid_next[scan_idx_reg] = 1'b1;
                end else if (scan_idx_reg != mbtc_pkg::TBL_LAST_IDX) begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mbtc_pkg::TBL_IDLE;
            valid_reg     <= '0;
            cmp_live_reg  <= 1'b0;
            scan_last_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            cmp_live_reg  <= cmp_live_next;
            scan_last_reg <= scan_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg  <= scan_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        key_addrs_reg <= key_addrs_next;
        key_ports_reg <= key_ports_next;
        key_start_reg <= key_start_next;
    end

    a_req_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (req.lookup || req.insert) |-> state_reg == mbtc_pkg::TBL_IDLE)
        else $error("table request while busy");

    a_hit_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (rsp.done && rsp.hit) |=> !valid_reg[$past(cmp_idx_reg)])
        else $error("matched entry not freed");

    a_insert_sets: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |=> valid_reg[$past(scan_idx_reg)])
        else $error("inserted entry not marked valid");

endmodule

[rtl/modbus_tcp_read_response_correlator_top.sv]
// ----------------------------------------------------------------------------
// modbus_tcp_read_response_correlator_top
// matches modbus/tcp read responses to stored requests and streams register words
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  frame byte, tlast = end of frame
//  m_*       out  m_tvalid/m_tready  one register word or end marker per beat
//  cfg_*     in   cfg_wr_en          service port
//
//  the beat carrying the response byte count and the beat ending a request
//  header start a table sweep, one entry per cycle, over up to TABLE_DEPTH
//  entries (256 at the default depth)
//  s_tready is low during a sweep and while an unaccepted result sits in m_*
//  reset clears the valid bits of all table entries at once, no clearing pass
//
module modbus_tcp_read_response_correlator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // service_port
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // frame_byte
    input  logic        s_tlast,       // end_of_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,       // func_code, start_address, reg_index, reg_value, pad
    output logic        m_tlast,       // last_of_record
    output logic [1:0]  m_tuser        // has_value, truncated
);

    mbtc_pkg::mbtc_state_t state_reg, state_next;

    logic [15:0] service_port_reg;

    // per-frame parse state
    logic [10:0] byte_position_reg, byte_position_next;
    logic [5:0]  ip_hdr_reg, ip_hdr_next;
    logic [5:0]  tcp_hdr_reg, tcp_hdr_next;
    logic [31:0] src_addr_reg, src_addr_next;
    logic [31:0] dst_addr_reg, dst_addr_next;
    logic [15:0] src_port_reg, src_port_next;
    logic [15:0] dst_port_reg, dst_port_next;
    logic [15:0] txn_reg, txn_next;
    logic [7:0]  func_reg, func_next;
    logic [15:0] req_start_reg, req_start_next;
    logic [7:0]  byte_cnt_reg, byte_cnt_next;
    logic [7:0]  word_hi_reg, word_hi_next;
    logic [15:0] rec_start_reg, rec_start_next;
    logic [6:0]  word_count_reg, word_count_next;
    logic        dropped_reg, dropped_next;
    logic        rec_active_reg, rec_active_next;
    logic        pend_eof_reg, pend_eof_next;

    // result register
    logic        m_valid_reg, m_valid_next;
    logic [47:0] m_data_reg, m_data_next;
    logic        m_last_reg, m_last_next;
    logic [1:0]  m_user_reg, m_user_next;

    mbtc_pkg::mbtc_tbl_req_t tbl_req;
    mbtc_pkg::mbtc_tbl_rsp_t tbl_rsp;

    logic        s_accept;
    logic [7:0]  b;
    logic [10:0] tcp_base;
    logic [10:0] mb_base;
    logic [10:0] mb_ofs;
    logic        in_payload;
    logic        is_read;
    logic        word_last;

    logic        emit;
    logic        emit_hv;
    logic [15:0] emit_val;
    logic        emit_last;
    logic        emit_trunc;
    logic [15:0] emit_start;
    logic        lookup_go;
    logic        frame_clear;
    logic        step_done;
    logic        step_eof;

    assign s_tready = (state_reg == mbtc_pkg::ST_PARSE) && !tbl_rsp.busy &&
                      (!m_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign b        = s_tdata;

    // tcp header starts after ethernet + ip header, modbus after tcp header
    assign tcp_base   = mbtc_pkg::POS_IP_VER_IHL + {5'd0, ip_hdr_reg};
    assign mb_base    = tcp_base + {5'd0, tcp_hdr_reg};
    assign mb_ofs     = byte_position_reg - mb_base;
    assign in_payload = !dropped_reg && (tcp_hdr_reg != 6'd0) &&
                        (byte_position_reg >= mb_base);
    assign is_read    = (func_reg == mbtc_pkg::FUNC_READ_HOLDING) ||
                        (func_reg == mbtc_pkg::FUNC_READ_INPUT);
    assign word_last  = ({1'b0, word_count_reg} + 8'd1) == {1'b0, byte_cnt_reg[7:1]};

    mbtc_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tbl_req),
        .rsp     (tbl_rsp)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mbtc_pkg::ST_PARSE: begin
                if (lookup_go) begin
                    state_next = mbtc_pkg::ST_LOOKUP;
                end
            end
            mbtc_pkg::ST_LOOKUP: begin
                if (tbl_rsp.done) begin
                    state_next = mbtc_pkg::ST_PARSE;
                end
            end
            default: state_next = mbtc_pkg::ST_PARSE;
        endcase
    end

    // byte parser, table requests and result formation
    always_comb begin
        byte_position_next = byte_position_reg;
        ip_hdr_next        = ip_hdr_reg;
        tcp_hdr_next       = tcp_hdr_reg;
        src_addr_next      = src_addr_reg;
        dst_addr_next      = dst_addr_reg;
        src_port_next      = src_port_reg;
        dst_port_next      = dst_port_reg;
        txn_next           = txn_reg;
        func_next          = func_reg;
        req_start_next     = req_start_reg;
        byte_cnt_next      = byte_cnt_reg;
        word_hi_next       = word_hi_reg;
        rec_start_next     = rec_start_reg;
        word_count_next    = word_count_reg;
        dropped_next       = dropped_reg;
        rec_active_next    = rec_active_reg;
        pend_eof_next      = pend_eof_reg;

        emit        = 1'b0;
        emit_hv     = 1'b0;
        emit_val    = 16'd0;
        emit_last   = 1'b0;
        emit_trunc  = 1'b0;
        emit_start  = rec_start_reg;
        lookup_go   = 1'b0;
        frame_clear = 1'b0;
        step_done   = 1'b0;
        step_eof    = 1'b0;

        tbl_req.lookup    = 1'b0;
        tbl_req.insert    = 1'b0;
        tbl_req.addrs     = {src_addr_reg, dst_addr_reg};
        tbl_req.ports_txn = {src_port_reg, dst_port_reg, txn_reg};
        tbl_req.start     = req_start_reg;

        unique case (state_reg)
            mbtc_pkg::ST_PARSE: begin
                if (s_accept) begin
                    if (!dropped_reg) begin
                        if (byte_position_reg >= mbtc_pkg::POS_SRC_ADDR_LO &&
                            byte_position_reg <= mbtc_pkg::POS_SRC_ADDR_HI) begin
                            src_addr_next = {src_addr_reg[23:0], b};
                        end
                        if (byte_position_reg >= mbtc_pkg::POS_DST_ADDR_LO &&
                            byte_position_reg <= mbtc_pkg::POS_DST_ADDR_HI) begin
                            dst_addr_next = {dst_addr_reg[23:0], b};
                        end
                        if (byte_position_reg == mbtc_pkg::POS_IP_VER_IHL) begin
                            ip_hdr_next = {b[3:0], 2'b00};
                            if (b[3:0] < mbtc_pkg::MIN_HDR_WORDS) begin
                                dropped_next = 1'b1;
                            end
                        end else if (byte_position_reg > mbtc_pkg::POS_IP_VER_IHL) begin
                            if (byte_position_reg == tcp_base ||
                                byte_position_reg == tcp_base + 11'd1) begin
                                src_port_next = {src_port_reg[7:0], b};
                            end
                            if (byte_position_reg == tcp_base + 11'd2 ||
                                byte_position_reg == tcp_base + 11'd3) begin
                                dst_port_next = {dst_port_reg[7:0], b};
                            end
                            if (byte_position_reg == tcp_base + 11'd3 &&
                                src_port_reg != service_port_reg &&
                                {dst_port_reg[7:0], b} != service_port_reg) begin
                                dropped_next = 1'b1;
                            end
                            if (byte_position_reg == tcp_base + mbtc_pkg::TCP_OFS_DATA_OFS &&
                                !dropped_next) begin
                                tcp_hdr_next = {b[7:4], 2'b00};
                                if (b[7:4] < mbtc_pkg::MIN_HDR_WORDS) begin
                                    dropped_next = 1'b1;
                                end
                            end
                            if (in_payload) begin
                                if (mb_ofs <= 11'd1) begin
                                    txn_next = {txn_reg[7:0], b};
                                end
                                if (mb_ofs == mbtc_pkg::MB_OFS_FUNC) begin
                                    func_next = b;
                                end
                                if (mb_ofs == mbtc_pkg::MB_OFS_BYTE_CNT) begin
                                    req_start_next = {b, 8'h00};
                                    byte_cnt_next  = b;
                                    if (src_port_reg == service_port_reg && is_read) begin
                                        lookup_go = 1'b1;
                                    end
                                end
                                if (mb_ofs == mbtc_pkg::MB_OFS_START_LO) begin
                                    req_start_next = {req_start_reg[15:8], b};
                                end
                                if (mb_ofs == mbtc_pkg::MB_OFS_INSERT &&
                                    dst_port_reg == service_port_reg && is_read) begin
                                    tbl_req.insert = 1'b1;
                                end
                                // record words: high byte on odd offsets, word on even
                                if (rec_active_reg && mb_ofs >= mbtc_pkg::MB_OFS_START_LO) begin
                                    if (mb_ofs[0]) begin
                                        word_hi_next = b;
                                    end else begin
                                        emit       = 1'b1;
                                        emit_hv    = 1'b1;
                                        emit_val   = {word_hi_reg, b};
                                        emit_last  = word_last || s_tlast;
                                        emit_trunc = !word_last && s_tlast;
                                        word_count_next = word_count_reg + 7'd1;
                                        if (word_last || s_tlast) begin
                                            rec_active_next = 1'b0;
                                        end
                                    end
                                end
                            end
                        end
                    end
                    if (lookup_go) begin
                        // swapped key: response travels server to client
                        tbl_req.lookup    = 1'b1;
                        tbl_req.addrs     = {dst_addr_reg, src_addr_reg};
                        tbl_req.ports_txn = {dst_port_reg, src_port_reg, txn_reg};
                        pend_eof_next     = s_tlast;
                    end else begin
                        step_done = 1'b1;
                        step_eof  = s_tlast;
                    end
                end
            end
            mbtc_pkg::ST_LOOKUP: begin
                if (tbl_rsp.done) begin
                    if (tbl_rsp.hit) begin
                        rec_start_next  = tbl_rsp.start;
                        word_count_next = 7'd0;
                        emit_start      = tbl_rsp.start;
                        if (byte_cnt_reg[7:1] == 7'd0) begin
                            emit      = 1'b1;
                            emit_last = 1'b1;
                        end else begin
                            rec_active_next = 1'b1;
                        end
                    end
                    step_done = 1'b1;
                    step_eof  = pend_eof_reg;
                end
            end
            default: begin
            end
        endcase

        if (step_done) begin
            if (step_eof) begin
                // frame ended inside a record without a word on this beat
                if (rec_active_next && !emit) begin
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    emit_trunc = 1'b1;
                end
                frame_clear = 1'b1;
            end else if (byte_position_reg < mbtc_pkg::POS_MAX) begin
                byte_position_next = byte_position_reg + 11'd1;
            end
        end

        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = {6'd0, emit_val, word_count_reg, emit_start, func_reg[2:0]};
            m_last_next  = emit_last;
            m_user_next  = {emit_trunc, emit_hv};
        end

        if (frame_clear) begin
            byte_position_next = '0;
            ip_hdr_next        = '0;
            tcp_hdr_next       = '0;
            src_addr_next      = '0;
            dst_addr_next      = '0;
            src_port_next      = '0;
            dst_port_next      = '0;
            txn_next           = '0;
            func_next          = '0;
            req_start_next     = '0;
            byte_cnt_next      = '0;
            word_hi_next       = '0;
            rec_start_next     = '0;
            word_count_next    = '0;
            dropped_next       = 1'b0;
            rec_active_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= mbtc_pkg::ST_PARSE;
            service_port_reg  <= mbtc_pkg::SERVICE_PORT_RESET;
            byte_position_reg <= '0;
            ip_hdr_reg        <= '0;
            tcp_hdr_reg       <= '0;
            src_addr_reg      <= '0;
            dst_addr_reg      <= '0;
            src_port_reg      <= '0;
            dst_port_reg      <= '0;
            txn_reg           <= '0;
            func_reg          <= '0;
            req_start_reg     <= '0;
            byte_cnt_reg      <= '0;
            word_hi_reg       <= '0;
            rec_start_reg     <= '0;
            word_count_reg    <= '0;
            dropped_reg       <= 1'b0;
            rec_active_reg    <= 1'b0;
            pend_eof_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            if (cfg_wr_en) begin
                service_port_reg <= cfg_wr_data;
            end
            byte_position_reg <= byte_position_next;
            ip_hdr_reg        <= ip_hdr_next;
            tcp_hdr_reg       <= tcp_hdr_next;
            src_addr_reg      <= src_addr_next;
            dst_addr_reg      <= dst_addr_next;
            src_port_reg      <= src_port_next;
            dst_port_reg      <= dst_port_next;
            txn_reg           <= txn_next;
            func_reg          <= func_next;
            req_start_reg     <= req_start_next;
            byte_cnt_reg      <= byte_cnt_next;
            word_hi_reg       <= word_hi_next;
            rec_start_reg     <= rec_start_next;
            word_count_reg    <= word_count_next;
            dropped_reg       <= dropped_next;
            rec_active_reg    <= rec_active_next;
            pend_eof_reg      <= pend_eof_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // result payload needs no reset
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    a_lookup_tbl_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mbtc_pkg::ST_LOOKUP) |-> tbl_rsp.busy)
        else $error("waiting on lookup with idle table");

    a_active_not_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        rec_active_reg |-> !dropped_reg)
        else $error("record active in dropped frame");

    a_no_emit_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !emit)
        else $error("result overwritten before taken");

endmodule

[verif/modbus_tcp_read_response_correlator_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modbus_tcp_read_response_correlator_top_tb
// checks the response correlator against a behavioral predictor: frames of
// modbus/tcp read requests and responses, directed corner frames, then random
// traffic under several idle and stall patterns and several service ports
// ----------------------------------------------------------------------------
module modbus_tcp_read_response_correlator_top_tb;
    import mbtc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 300;   // longer than one full table sweep

    // one frame byte beat on the input channel
    typedef struct packed {
        logic [7:0] data;
        logic       eof;
    } frame_beat_t;

    // one register word or end marker on the result channel
    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] start;
        logic [6:0]  index;
        logic [15:0] value;
        logic        has_value;
        logic        last;
        logic        truncated;
    } reg_word_t;

    // connection key of an outstanding request, as seen from the client
    typedef struct packed {
        logic [31:0] cli_addr;
        logic [31:0] srv_addr;
        logic [15:0] cli_port;
        logic [15:0] srv_port;
        logic [15:0] txn;
        logic [7:0]  func;
    } conn_key_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    modbus_tcp_read_response_correlator_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    frame_beat_t pending_beats[$];
    reg_word_t   expected_words[$];
    conn_key_t   open_requests[$];
    logic [7:0]  mb_body[$];

    int          src_idle_pct;
    int          snk_stall_pct;
    int          errors;
    int          quiet_cycles;
    logic [15:0] gen_port;

    // predictor state: table and per-frame parse registers
    logic        tbl_valid[TABLE_DEPTH];
    logic [63:0] tbl_addrs[TABLE_DEPTH];
    logic [47:0] tbl_ports[TABLE_DEPTH];
    logic [15:0] tbl_start[TABLE_DEPTH];
    logic [15:0] svc_port;
    int          pos;
    int          ip_len;
    int          tcp_len;
    logic [31:0] f_src_addr;
    logic [31:0] f_dst_addr;
    logic [15:0] f_src_port;
    logic [15:0] f_dst_port;
    logic [15:0] f_txn;
    logic [7:0]  f_func;
    logic [15:0] f_req_start;
    logic [7:0]  f_byte_cnt;
    logic [7:0]  f_word_hi;
    logic [15:0] f_rec_start;
    logic [6:0]  f_word_cnt;
    logic        f_dropped;
    logic        f_active;

    task automatic clear_parse();
        pos         = 0;
        ip_len      = 0;
        tcp_len     = 0;
        f_src_addr  = '0;
        f_dst_addr  = '0;
        f_src_port  = '0;
        f_dst_port  = '0;
        f_txn       = '0;
        f_func      = '0;
        f_req_start = '0;
        f_byte_cnt  = '0;
        f_word_hi   = '0;
        f_rec_start = '0;
        f_word_cnt  = '0;
        f_dropped   = 1'b0;
        f_active    = 1'b0;
    endtask

    task automatic push_word(input logic hv, input logic [15:0] val, input logic lst,
                             input logic trunc);
        reg_word_t w;
        w.func      = f_func[2:0];
        w.start     = f_rec_start;
        w.index     = f_word_cnt;
        w.value     = hv ? val : 16'd0;
        w.has_value = hv;
        w.last      = lst;
        w.truncated = trunc;
        expected_words.push_back(w);
    endtask

    // advances the correlator state by one accepted frame byte
    task automatic correlate_byte(input logic [7:0] b, input logic eof);
        int          t;
        int          o;
        logic        emitted;
        logic        hit;
        logic        lst;
        logic        is_read;
        logic [63:0] akey;
        logic [47:0] pkey;
        emitted = 1'b0;
        if (!f_dropped) begin
            if (pos >= 26 && pos <= 29) f_src_addr = {f_src_addr[23:0], b};
            if (pos >= 30 && pos <= 33) f_dst_addr = {f_dst_addr[23:0], b};
            if (pos == 14) begin
                ip_len = b[3:0] * 4;
                if (ip_len < 20) f_dropped = 1'b1;
            end else if (pos > 14) begin
                t = 14 + ip_len;
                if (pos == t || pos == t + 1) f_src_port = {f_src_port[7:0], b};
                if (pos == t + 2 || pos == t + 3) f_dst_port = {f_dst_port[7:0], b};
                if (pos == t + 3 && f_src_port != svc_port && f_dst_port != svc_port)
                    f_dropped = 1'b1;
                if (pos == t + 12 && !f_dropped) begin
                    tcp_len = b[7:4] * 4;
                    if (tcp_len < 20) f_dropped = 1'b1;
                end
                if (!f_dropped && tcp_len != 0 && pos >= t + tcp_len) begin
                    o = pos - (t + tcp_len);
                    is_read = (f_func == FUNC_READ_HOLDING) || (f_func == FUNC_READ_INPUT);
                    if (o <= 1) f_txn = {f_txn[7:0], b};
                    if (o == 7) f_func = b;
                    is_read = (f_func == FUNC_READ_HOLDING) || (f_func == FUNC_READ_INPUT);
                    if (o == 8) begin
                        f_req_start = {b, 8'd0};
                        f_byte_cnt  = b;
                        if (f_src_port == svc_port && is_read) begin
                            // response direction: look up the swapped key
                            akey = {f_dst_addr, f_src_addr};
                            pkey = {f_dst_port, f_src_port, f_txn};
                            hit  = 1'b0;
                            for (int i = 0; i < TABLE_DEPTH; i++) begin
                                if (!hit && tbl_valid[i] && tbl_addrs[i] == akey &&
                                    tbl_ports[i] == pkey) begin
                                    hit          = 1'b1;
                                    f_rec_start  = tbl_start[i];
                                    tbl_valid[i] = 1'b0;
                                end
                            end
                            if (hit) begin
                                f_word_cnt = '0;
                                if (f_byte_cnt[7:1] == 0) begin
                                    push_word(1'b0, 16'd0, 1'b1, 1'b0);
                                    emitted = 1'b1;
                                end else begin
                                    f_active = 1'b1;
                                end
                            end
                        end
                    end
                    if (o == 9) f_req_start[7:0] = b;
                    if (o == 11 && f_dst_port == svc_port && is_read) begin
                        hit = 1'b0;
                        for (int i = 0; i < TABLE_DEPTH; i++) begin
                            if (!hit && !tbl_valid[i]) begin
                                hit          = 1'b1;
                                tbl_valid[i] = 1'b1;
                                tbl_addrs[i] = {f_src_addr, f_dst_addr};
                                tbl_ports[i] = {f_src_port, f_dst_port, f_txn};
                                tbl_start[i] = f_req_start;
                            end
                        end
                    end
                    if (f_active && o >= 9) begin
                        if (((o - 9) % 2) == 0) begin
                            f_word_hi = b;
                        end else begin
                            lst = (int'(f_word_cnt) + 1 == int'(f_byte_cnt[7:1]));
                            push_word(1'b1, {f_word_hi, b}, lst || eof, !lst && eof);
                            emitted    = 1'b1;
                            f_word_cnt = f_word_cnt + 7'd1;
                            if (lst || eof) f_active = 1'b0;
                        end
                    end
                end
            end
        end
        if (eof) begin
            // frame cut before the record completed
            if (f_active && !emitted) push_word(1'b0, 16'd0, 1'b1, 1'b1);
            clear_parse();
        end else if (pos < 2047) begin
            pos = pos + 1;
        end
    endtask

    // wraps mb_body into ethernet/ipv4/tcp headers and queues it as beats
    task automatic add_frame(input logic [3:0] ihl, input logic [3:0] doff,
                             input logic [31:0] sa, input logic [31:0] da,
                             input logic [15:0] sp, input logic [15:0] dp,
                             input int cut);
        logic [7:0]  fr[$];
        frame_beat_t fb;
        for (int i = 0; i < 14; i++) fr.push_back(8'($urandom));
        fr.push_back({4'($urandom), ihl});
        for (int i = 15; i < 26; i++) fr.push_back(8'($urandom));
        for (int i = 3; i >= 0; i--) fr.push_back(sa[i*8 +: 8]);
        for (int i = 3; i >= 0; i--) fr.push_back(da[i*8 +: 8]);
        for (int i = 20; i < ihl * 4; i++) fr.push_back(8'($urandom));
        fr.push_back(sp[15:8]);
        fr.push_back(sp[7:0]);
        fr.push_back(dp[15:8]);
        fr.push_back(dp[7:0]);
        for (int i = 4; i < 12; i++) fr.push_back(8'($urandom));
        fr.push_back({doff, 4'($urandom)});
        for (int i = 13; i < doff * 4; i++) fr.push_back(8'($urandom));
        foreach (mb_body[i]) fr.push_back(mb_body[i]);
        if (cut > 0) begin
            while (fr.size() > cut) void'(fr.pop_back());
        end
        foreach (fr[i]) begin
            fb.data = fr[i];
            fb.eof  = (i == fr.size() - 1);
            pending_beats.push_back(fb);
        end
    endtask

    task automatic mbap(input logic [15:0] txn, input logic [7:0] fn);
        mb_body = {};
        mb_body.push_back(txn[15:8]);
        mb_body.push_back(txn[7:0]);
        mb_body.push_back(8'd0);
        mb_body.push_back(8'd0);
        mb_body.push_back(8'($urandom));
        mb_body.push_back(8'($urandom));
        mb_body.push_back(8'($urandom));
        mb_body.push_back(fn);
    endtask

    // request with function fn from a random client to the server port, remembered for a reply
    task automatic send_request(input logic [7:0] fn, input int cut);
        conn_key_t k;
        logic [15:0] st;
        k.cli_addr = $urandom;
        k.srv_addr = $urandom;
        k.cli_port = $urandom;
        k.srv_port = gen_port;
        k.txn      = $urandom;
        k.func     = fn;
        st         = $urandom;
        mbap(k.txn, fn);
        mb_body.push_back(st[15:8]);
        mb_body.push_back(st[7:0]);
        mb_body.push_back(8'($urandom));
        mb_body.push_back(8'($urandom));
        add_frame(4'd5, 4'd5, k.cli_addr, k.srv_addr, k.cli_port, k.srv_port, cut);
        open_requests.push_back(k);
    endtask

    task automatic send_response(input conn_key_t k, input int bc, input int cut,
                                 input int extra);
        mbap(k.txn, k.func);
        mb_body.push_back(8'(bc));
        for (int i = 0; i < bc + extra; i++) mb_body.push_back(8'($urandom));
        add_frame(4'($urandom_range(5, 15)), 4'($urandom_range(5, 15)), k.srv_addr,
                  k.cli_addr, k.srv_port, k.cli_port, cut);
    endtask

    task automatic reply_random(input int bc, input int cut);
        int        j;
        conn_key_t k;
        j = $urandom_range(open_requests.size() - 1);
        k = open_requests[j];
        open_requests.delete(j);
        send_response(k, bc, cut, $urandom_range(3));
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || s_tvalid || expected_words.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_port(input logic [15:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        gen_port = v;
    endtask

    // driver: next frame byte, unless randomly idle, when the current beat is taken or none is up
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
            if (!s_tvalid || s_tready) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    frame_beat_t fb;
                    fb = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= fb.data;
                    s_tlast  <= fb.eof;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: predicts on each accepted byte, checks each accepted result beat
    always @(posedge aclk) begin
        if (aresetn) begin
            reg_word_t got;
            reg_word_t want;
            if (cfg_wr_en) svc_port = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                got.func      = m_tdata[2:0];
                got.start     = m_tdata[18:3];
                got.index     = m_tdata[25:19];
                got.value     = m_tdata[41:26];
                got.has_value = m_tuser[0];
                got.truncated = m_tuser[1];
                got.last      = m_tlast;
                if (expected_words.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat %h", $time, got);
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: result mismatch exp %h got %h", $time, want, got);
                    end
                end
            end
            if (s_tvalid && s_tready) correlate_byte(s_tdata, s_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        conn_key_t   k;
        logic [31:0] a;
        int          rand_beats;
        int          rand_records;
        int          sel;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        errors       = 0;
        quiet_cycles = 0;
        svc_port     = SERVICE_PORT_RESET;
        gen_port     = SERVICE_PORT_RESET;
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        clear_parse();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed frames at the reset service port
        send_request(FUNC_READ_HOLDING, 0);
        reply_random(4, 0);
        send_request(FUNC_READ_INPUT, 0);
        reply_random(0, 0);                       // empty record
        send_request(FUNC_READ_HOLDING, 0);
        reply_random(5, 0);                       // odd byte count
        send_request(FUNC_READ_INPUT, 0);
        reply_random(254, 0);                     // largest record, index to 126
        send_request(FUNC_READ_HOLDING, 0);
        k = open_requests.pop_back();
        send_response(k, 8, 14 + 20 + 20 + 9 + 3, 0);   // cut at a fixed frame length
        send_request(FUNC_READ_HOLDING, 0);
        k = open_requests.pop_back();
        send_response(k, 8, 14 + 20 + 20 + 9 + 4, 0);   // cut one byte later
        send_request(FUNC_READ_HOLDING, 0);
        k = open_requests.pop_back();
        send_response(k, 6, 0, 20);               // trailing bytes after record
        k.txn = k.txn + 16'd1;
        send_response(k, 2, 0, 0);                // no stored request
        send_request(FUNC_READ_HOLDING, 14 + 20 + 20 + 10);   // short, never stored
        k = open_requests.pop_back();
        send_response(k, 2, 0, 0);
        send_request(8'h10, 0);                   // not a read
        reply_random(2, 0);
        // short ip header, short tcp header, foreign port
        mbap(16'h0001, FUNC_READ_HOLDING);
        add_frame(4'd4, 4'd5, 32'h0, 32'hFFFF_FFFF, gen_port, 16'd1, 0);
        add_frame(4'd0, 4'd5, 32'h0, 32'h0, 16'd0, gen_port, 0);
        add_frame(4'd5, 4'd4, 32'hFFFF_FFFF, 32'h0, gen_port, 16'hFFFF, 0);
        add_frame(4'd5, 4'd5, 32'h1, 32'h2, 16'd0, 16'hFFFF, 0);
        // self-addressed: first copy stores, second copy finds itself
        a = $urandom;
        mbap(16'hFFFF, FUNC_READ_INPUT);
        mb_body.push_back(8'h02);
        mb_body.push_back(8'hFF);
        mb_body.push_back(8'hAB);
        mb_body.push_back(8'hCD);
        add_frame(4'd5, 4'd5, a, a, gen_port, gen_port, 0);
        add_frame(4'd5, 4'd5, a, a, gen_port, gen_port, 0);
        // long frame saturates the byte position
        mb_body = {};
        for (int i = 0; i < 2100; i++) mb_body.push_back(8'($urandom));
        add_frame(4'd5, 4'd5, $urandom, $urandom, gen_port, $urandom, 0);
        wait_idle();

        // table full: more requests than entries, then drain them
        write_port(16'($urandom));
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        open_requests = {};
        for (int i = 0; i < TABLE_DEPTH + 4; i++) send_request(FUNC_READ_HOLDING, 0);
        while (open_requests.size() != 0) reply_random($urandom_range(4), 0);
        wait_idle();

        // random traffic, one service port and idle pattern per phase
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_port(16'd0);
                    src_idle_pct = 0;  snk_stall_pct = 0;
                end
                1: begin
                    write_port(16'hFFFF);
                    src_idle_pct = 60; snk_stall_pct = 0;
                end
                2: begin
                    write_port(SERVICE_PORT_RESET);
                    src_idle_pct = 0;  snk_stall_pct = 60;
                end
                default: begin
                    write_port(16'($urandom));
                    src_idle_pct = 28; snk_stall_pct = 28;
                end
            endcase
            rand_beats   = pending_beats.size();
            rand_records = 0;
            open_requests = {};
            while (pending_beats.size() - rand_beats < 150 || rand_records < 16) begin
                sel = $urandom_range(99);
                if (sel < 40 || (sel < 80 && open_requests.size() == 0)) begin
                    send_request($urandom_range(1) ? FUNC_READ_HOLDING : FUNC_READ_INPUT,
                                 ($urandom_range(9) == 0) ? $urandom_range(30, 70) : 0);
                end else if (sel < 80) begin
                    reply_random(($urandom_range(9) == 0) ? $urandom_range(255)
                                                          : $urandom_range(12),
                                 ($urandom_range(6) == 0) ? $urandom_range(50, 80) : 0);
                    rand_records++;
                end else begin
                    // noise: odd headers, foreign ports, other functions, runts
                    mbap($urandom, 8'($urandom_range(7)));
                    for (int i = $urandom_range(8); i > 0; i--)
                        mb_body.push_back(8'($urandom));
                    add_frame(4'($urandom), 4'($urandom), $urandom, $urandom,
                              $urandom_range(1) ? gen_port : 16'($urandom), $urandom,
                              ($urandom_range(3) == 0) ? $urandom_range(1, 40) : 0);
                end
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/mbtc_pkg.sv
rtl/mbtc_ram.sv
rtl/mbtc_table.sv
rtl/modbus_tcp_read_response_correlator_top.sv
verif/modbus_tcp_read_response_correlator_top_tb.sv
